FILE: design/mcbtp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the composition data bind-target parser.
// Used by the front parser, the queue, the back emitter and the top level.
package mcbtp_pkg;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_ELEM   = 2'd1,
    PH_SIG    = 2'd2,
    PH_VENDOR = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    KIND_SIG    = 2'd0,
    KIND_VENDOR = 2'd1,
    KIND_OK     = 2'd2,
    KIND_SHORT  = 2'd3
  } kind_t;

  localparam logic [3:0]  HDR_FEAT_LO    = 4'd8;
  localparam logic [3:0]  HDR_FEAT_HI    = 4'd9;
  localparam logic [3:0]  HDR_LAST       = 4'd9;
  localparam logic [3:0]  HDR_LEN        = 4'd10;
  localparam logic [1:0]  FIDX_SIG_CNT   = 2'd2;
  localparam logic [1:0]  FIDX_VEN_CNT   = 2'd3;
  localparam logic [1:0]  FIDX_VEN_LAST  = 2'd3;
  localparam logic [15:0] SIG_ID_CFG_SRV = 16'h0000;
  localparam logic [15:0] SIG_ID_CFG_CLI = 16'h0001;
  localparam int          RPR_FEAT_BIT   = 4;
  localparam int          QUEUE_DEPTH_DEF = 4;

  // Results caused by one input byte: an optional target and an optional done.
  typedef struct packed {
    logic        tgt_vld;
    kind_t       tgt_kind;
    logic [15:0] addr;
    logic [15:0] mid;
    logic [15:0] cid;
    logic        done_vld;
    kind_t       done_kind;
    logic [15:0] feat;
  } entry_t;

endpackage

FILE: design/mcbtp_front.sv
`timescale 1ns / 1ps
// Front parser: walks the byte stream and pushes a queue entry for each byte with a result.
// Depends on mcbtp_pkg.
module mcbtp_front import mcbtp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  input  logic [15:0] primary_address,
  output logic        push,
  output entry_t      entry
);

  phase_t      phase_r, phase_nxt;
  logic [3:0]  hc_r, hc_nxt;
  logic [1:0]  fbi_r, fbi_nxt;
  logic [7:0]  sig_r, sig_nxt;
  logic [7:0]  ven_r, ven_nxt;
  logic [23:0] partial_r, partial_nxt;
  logic [15:0] elem_r, elem_nxt;
  logic [15:0] feat_r, feat_nxt;
  logic [15:0] feat_step;
  logic [15:0] elem_base;
  logic [7:0]  sig_dec;
  logic [7:0]  ven_dec;
  logic [15:0] sig_mid;

  assign elem_base = (phase_r == PH_HEADER && hc_r == '0) ? primary_address : elem_r;
  assign sig_dec   = sig_r - 8'd1;
  assign ven_dec   = ven_r - 8'd1;
  assign sig_mid   = {data_byte, partial_r[7:0]};

  always_comb begin
    phase_nxt   = phase_r;
    hc_nxt      = hc_r;
    fbi_nxt     = fbi_r;
    sig_nxt     = sig_r;
    ven_nxt     = ven_r;
    partial_nxt = partial_r;
    elem_nxt    = elem_base;
    feat_step   = feat_r;
    case (phase_r)
      PH_HEADER: begin
        if (hc_r == HDR_FEAT_LO) feat_step[7:0] = data_byte;
        if (hc_r == HDR_FEAT_HI) feat_step[15:8] = data_byte;
        if (hc_r == HDR_LAST) begin
          hc_nxt    = HDR_LEN;
          phase_nxt = PH_ELEM;
          fbi_nxt   = '0;
        end else begin
          hc_nxt = hc_r + 4'd1;
        end
      end
      PH_ELEM: begin
        case (fbi_r)
          FIDX_SIG_CNT: begin
            sig_nxt = data_byte;
            fbi_nxt = FIDX_VEN_CNT;
          end
          FIDX_VEN_CNT: begin
            ven_nxt     = data_byte;
            fbi_nxt     = '0;
            partial_nxt = '0;
            if (sig_r != '0) begin
              phase_nxt = PH_SIG;
            end else if (data_byte != '0) begin
              phase_nxt = PH_VENDOR;
            end else begin
              phase_nxt = PH_ELEM;
              elem_nxt  = elem_base + 16'd1;
            end
          end
          default: begin
            fbi_nxt = fbi_r + 2'd1;
          end
        endcase
      end
      PH_SIG: begin
        if (fbi_r == '0) begin
          partial_nxt[7:0] = data_byte;
          fbi_nxt          = 2'd1;
        end else begin
          sig_nxt     = sig_dec;
          fbi_nxt     = '0;
          partial_nxt = '0;
          if (sig_dec == '0) begin
            if (ven_r != '0) begin
              phase_nxt = PH_VENDOR;
            end else begin
              phase_nxt = PH_ELEM;
              elem_nxt  = elem_base + 16'd1;
            end
          end
        end
      end
      default: begin
        if (fbi_r != FIDX_VEN_LAST) begin
          partial_nxt[fbi_r*8 +: 8] = data_byte;
          fbi_nxt = fbi_r + 2'd1;
        end else begin
          ven_nxt     = ven_dec;
          fbi_nxt     = '0;
          partial_nxt = '0;
          if (ven_dec == '0) begin
            phase_nxt = PH_ELEM;
            elem_nxt  = elem_base + 16'd1;
          end
        end
      end
    endcase
    feat_nxt = feat_step;
    if (last_byte) begin
      phase_nxt   = PH_HEADER;
      hc_nxt      = '0;
      fbi_nxt     = '0;
      sig_nxt     = '0;
      ven_nxt     = '0;
      partial_nxt = '0;
      feat_nxt    = '0;
    end
  end

  always_comb begin
    entry            = '0;
    entry.addr       = elem_base;
    entry.feat       = feat_step;
    entry.tgt_kind   = KIND_SIG;
    entry.done_vld   = last_byte;
    entry.done_kind  = KIND_OK;
    case (phase_r)
      PH_SIG: begin
        entry.mid     = sig_mid;
        entry.tgt_vld = (fbi_r != '0) && (sig_mid != SIG_ID_CFG_SRV) &&
                        (sig_mid != SIG_ID_CFG_CLI);
      end
      PH_VENDOR: begin
        entry.tgt_kind = KIND_VENDOR;
        entry.mid      = {data_byte, partial_r[23:16]};
        entry.cid      = partial_r[15:0];
        entry.tgt_vld  = (fbi_r == FIDX_VEN_LAST);
      end
      PH_HEADER: begin
        if (hc_r != HDR_LAST) begin
          entry.done_kind = KIND_SHORT;
          entry.feat      = '0;
        end
      end
      default: begin
        entry.tgt_vld = 1'b0;
      end
    endcase
    push = accept && (entry.tgt_vld || entry.done_vld);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HEADER;
      hc_r      <= '0;
      fbi_r     <= '0;
      sig_r     <= '0;
      ven_r     <= '0;
      partial_r <= '0;
      elem_r    <= '0;
      feat_r    <= '0;
    end else if (accept) begin
      phase_r   <= phase_nxt;
      hc_r      <= hc_nxt;
      fbi_r     <= fbi_nxt;
      sig_r     <= sig_nxt;
      ven_r     <= ven_nxt;
      partial_r <= partial_nxt;
      elem_r    <= elem_nxt;
      feat_r    <= feat_nxt;
    end
  end

endmodule

FILE: design/mcbtp_queue.sv
`timescale 1ns / 1ps
// Short queue of classified entries between the front parser and the back emitter.
// Depends on mcbtp_pkg.
module mcbtp_queue import mcbtp_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_entry,
  input  logic   pop,
  output logic   full,
  output logic   head_vld,
  output entry_t head_entry
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  entry_t          slot_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;

  assign full       = (count_r == CW'(DEPTH));
  assign head_vld   = (count_r != '0);
  assign head_entry = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    count_nxt  = count_r;
    if (push && !pop) count_nxt = count_r + 1'b1;
    if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_nxt;
      if (pop)  rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

FILE: design/mcbtp_back.sv
`timescale 1ns / 1ps
// Back emitter: turns each queue entry into one or two results in an output register.
// Depends on mcbtp_pkg.
module mcbtp_back import mcbtp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        head_vld,
  input  entry_t      head_entry,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_result_kind,
  output logic [15:0] out_element_address,
  output logic [15:0] out_model_id,
  output logic [15:0] out_company_id,
  output logic [15:0] out_features,
  output logic        out_remote_prov_server,
  output logic        out_last_result
);

  logic        vld_r, vld_nxt;
  logic        tgt_sent_r, tgt_sent_nxt;
  logic        load;
  logic        send_tgt;
  kind_t       kind_r, kind_nxt;
  logic [15:0] addr_r, addr_nxt;
  logic [15:0] mid_r, mid_nxt;
  logic [15:0] cid_r, cid_nxt;
  logic [15:0] feat_r, feat_nxt;
  logic        last_r, last_nxt;

  assign load     = head_vld && (!vld_r || !out_stall);
  assign send_tgt = head_entry.tgt_vld && !tgt_sent_r;

  always_comb begin
    vld_nxt      = vld_r && out_stall;
    tgt_sent_nxt = tgt_sent_r;
    pop          = 1'b0;
    kind_nxt     = kind_r;
    addr_nxt     = addr_r;
    mid_nxt      = mid_r;
    cid_nxt      = cid_r;
    feat_nxt     = feat_r;
    last_nxt     = last_r;
    if (load) begin
      vld_nxt  = 1'b1;
      feat_nxt = head_entry.feat;
      if (send_tgt) begin
        kind_nxt = head_entry.tgt_kind;
        addr_nxt = head_entry.addr;
        mid_nxt  = head_entry.mid;
        cid_nxt  = head_entry.cid;
        last_nxt = !head_entry.done_vld;
        pop          = !head_entry.done_vld;
        tgt_sent_nxt = head_entry.done_vld;
      end else begin
        kind_nxt     = head_entry.done_kind;
        addr_nxt     = '0;
        mid_nxt      = '0;
        cid_nxt      = '0;
        last_nxt     = 1'b1;
        pop          = 1'b1;
        tgt_sent_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r      <= 1'b0;
      tgt_sent_r <= 1'b0;
    end else begin
      vld_r      <= vld_nxt;
      tgt_sent_r <= tgt_sent_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    addr_r <= addr_nxt;
    mid_r  <= mid_nxt;
    cid_r  <= cid_nxt;
    feat_r <= feat_nxt;
    last_r <= last_nxt;
  end

  assign out_valid              = vld_r;
  assign out_result_kind        = kind_r;
  assign out_element_address    = addr_r;
  assign out_model_id           = mid_r;
  assign out_company_id         = cid_r;
  assign out_features           = feat_r;
  assign out_remote_prov_server = feat_r[RPR_FEAT_BIT];
  assign out_last_result        = last_r;

endmodule

FILE: design/mesh_composition_bind_target_parser.sv
`timescale 1ns / 1ps
// Top level of the composition data page 0 bind-target parser.
// Depends on mcbtp_pkg, mcbtp_front, mcbtp_queue and mcbtp_back.
//
//   Port group  Direction  Handshake          Request
//   in_*        input      in_valid/in_stall  one message byte with last flag
//   out_*       output     out_valid/out_stall one bind target or done result
//   cfg_*       input      cfg_valid/cfg_ready primary element address
//
// One byte is accepted per cycle while the queue has room.
// A result passes through the queue and then the back emitter's output register to reach out_valid.
// A byte that yields both a target and a done result gives two output results, the target first.
// in_stall rises only when the QUEUE_DEPTH-entry queue is full.
// Reset is synchronous; it clears the parser, the queue and the primary address.
module mesh_composition_bind_target_parser import mcbtp_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_result_kind,
  output logic [15:0] out_element_address,
  output logic [15:0] out_model_id,
  output logic [15:0] out_company_id,
  output logic [15:0] out_features,
  output logic        out_remote_prov_server,
  output logic        out_last_result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_primary_address
);

  logic [15:0] primary_address_r;
  logic        accept;
  logic        push;
  logic        pop;
  logic        full;
  logic        head_vld;
  entry_t      push_entry;
  entry_t      head_entry;

  assign cfg_ready = 1'b1;
  assign in_stall  = full;
  assign accept    = in_valid && !full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      primary_address_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      primary_address_r <= cfg_primary_address;
    end
  end

  mcbtp_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (accept),
    .data_byte       (in_data_byte),
    .last_byte       (in_last_byte),
    .primary_address (primary_address_r),
    .push            (push),
    .entry           (push_entry)
  );

  mcbtp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (full),
    .head_vld   (head_vld),
    .head_entry (head_entry)
  );

  mcbtp_back u_back (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .head_vld               (head_vld),
    .head_entry             (head_entry),
    .pop                    (pop),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_result_kind        (out_result_kind),
    .out_element_address    (out_element_address),
    .out_model_id           (out_model_id),
    .out_company_id         (out_company_id),
    .out_features           (out_features),
    .out_remote_prov_server (out_remote_prov_server),
    .out_last_result        (out_last_result)
  );

endmodule
